@@ hw/rtl/cgpe_pkg.sv @@
`default_nettype none

package cgpe_pkg;

   localparam int NODE_W = 6;
   localparam int LEN_W  = 16;
   localparam int FUNC_W = 2;
   localparam int CNT_W  = 7;

   localparam int MAX_NODES_DEF = 64;
   localparam int LEN_BITS_DEF  = 16;

   localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PATH = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_NBR  = 2'd2;

   typedef struct packed {
      logic capture;
      logic write_mem;
      logic locate;
      logic load_single;
      logic single_err;
      logic load_hop;
   } ctrl_cmd_type;

   typedef struct packed {
      logic func_load;
      logic func_path;
      logic func_nbr;
      logic range_err;
      logic loc_empty;
      logic hop_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/cgpe_ctrl.sv @@
`default_nettype none

module cgpe_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  cgpe_pkg::dp_status_type status,
   output cgpe_pkg::ctrl_cmd_type  cmd
);
   import cgpe_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_LOCATE = 3'd2;
   localparam logic [2:0] ST_HOPS   = 3'd3;
   localparam logic [2:0] ST_ERR    = 3'd4;
   localparam logic [2:0] ST_EMPTY  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!(status.func_load || status.func_path || status.func_nbr)) begin
               state_in = ST_IDLE;
            end else if (status.range_err) begin
               state_in = ST_ERR;
            end else if (status.func_load) begin
               cmd.write_mem = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            cmd.locate = 1'b1;
            state_in = status.loc_empty ? ST_EMPTY : ST_HOPS;
         end
         ST_HOPS: begin
            if (status.out_free) begin
               cmd.load_hop = 1'b1;
               if (status.hop_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (status.out_free) begin
               cmd.load_single = 1'b1;
               cmd.single_err = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (status.out_free) begin
               cmd.load_single = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/cgpe_datapath.sv @@
`default_nettype none

module cgpe_datapath #(
   parameter int MAX_NODES = cgpe_pkg::MAX_NODES_DEF,
   parameter int LEN_BITS  = cgpe_pkg::LEN_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  cgpe_pkg::ctrl_cmd_type             cmd,
   output cgpe_pkg::dp_status_type            status,
   input  wire [cgpe_pkg::FUNC_W-1:0]         req_func,
   input  wire [cgpe_pkg::NODE_W-1:0]         req_position,
   input  wire [cgpe_pkg::NODE_W-1:0]         req_node_id,
   input  wire [cgpe_pkg::LEN_W-1:0]          req_edge_len,
   input  wire [cgpe_pkg::NODE_W-1:0]         req_target_node,
   input  wire                                csr_wr_en,
   input  wire [cgpe_pkg::CNT_W-1:0]          csr_wr_data,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [cgpe_pkg::NODE_W-1:0]        rsp_hop_node,
   output logic [cgpe_pkg::LEN_W-1:0]         rsp_hop_len,
   output logic                               rsp_path_empty,
   output logic                               rsp_range_error,
   output logic                               rsp_last
);
   import cgpe_pkg::*;

   localparam int POS_W = $clog2(MAX_NODES);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

   logic [CNT_W-1:0]  node_count_ff;
   logic [FUNC_W-1:0] func_ff;
   logic [NODE_W-1:0] pos_ff;
   logic [NODE_W-1:0] node_ff;
   logic [NODE_W-1:0] tgt_ff;
   logic [LEN_W-1:0]  edge_ff;

   logic [POS_W-1:0]    o2n_mem [MAX_NODES];
   logic [POS_W-1:0]    n2o_mem [MAX_NODES];
   logic [LEN_BITS-1:0] len_mem [MAX_NODES];

   logic [POS_W-1:0]    pos_a_ff;
   logic [POS_W-1:0]    pos_b_ff;
   logic [POS_W-1:0]    hop_node_rd_ff;
   logic [LEN_BITS-1:0] hop_len_rd_ff;

   logic [POS_W-1:0] cur_ff, cur_in;
   logic [POS_W-1:0] end_ff, end_in;
   logic             desc_ff, desc_in;
   logic             flip_ff, flip_in;

   logic [CNT_W-1:0]          n_eff;
   logic [CNT_W-1:0]          a_ext;
   logic                      has_left;
   logic                      has_right;
   logic [POS_W-1:0]          node_addr;
   logic [LEN_W+LEN_BITS-1:0] edge_wide;
   logic [LEN_W+LEN_BITS-1:0] len_wide;
   logic [NODE_W+POS_W-1:0]   node_wide;

   logic                rsp_valid_ff;
   logic [NODE_W-1:0]   hop_node_ff;
   logic [LEN_W-1:0]    hop_len_ff;
   logic                empty_ff;
   logic                err_ff;
   logic                last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         pos_ff  <= req_position;
         node_ff <= req_node_id;
         tgt_ff  <= req_target_node;
         edge_ff <= req_edge_len;
      end
   end

   assign n_eff = (node_count_ff > MAX_CNT) ? MAX_CNT : node_count_ff;
   assign a_ext = {{(CNT_W-POS_W){1'b0}}, pos_a_ff};
   assign has_left = (pos_a_ff != '0);
   assign has_right = ((a_ext + CNT_W'(1)) < n_eff);
   assign edge_wide = {{LEN_BITS{1'b0}}, edge_ff};

   always_comb begin
      status.func_load = (func_ff == FUNC_LOAD);
      status.func_path = (func_ff == FUNC_PATH);
      status.func_nbr  = (func_ff == FUNC_NBR);
      status.range_err = ({1'b0, node_ff} >= n_eff)
         || (status.func_load && ({1'b0, pos_ff} >= n_eff))
         || (status.func_path && ({1'b0, tgt_ff} >= n_eff));
      if (status.func_path) begin
         status.loc_empty = (node_ff == tgt_ff) || (pos_a_ff == pos_b_ff);
      end else begin
         status.loc_empty = !has_left && !has_right;
      end
      status.hop_last = (cur_ff == end_ff);
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      cur_in  = cur_ff;
      end_in  = end_ff;
      desc_in = desc_ff;
      flip_in = flip_ff;
      if (cmd.locate) begin
         flip_in = 1'b0;
         if (func_ff == FUNC_PATH) begin
            if (pos_a_ff < pos_b_ff) begin
               desc_in = 1'b0;
               cur_in  = pos_a_ff + POS_W'(1);
               end_in  = pos_b_ff;
            end else begin
               desc_in = 1'b1;
               cur_in  = pos_a_ff;
               end_in  = pos_b_ff + POS_W'(1);
            end
         end else if (has_left) begin
            desc_in = 1'b1;
            cur_in  = pos_a_ff;
            flip_in = has_right;
            end_in  = has_right ? (pos_a_ff + POS_W'(1)) : pos_a_ff;
         end else begin
            desc_in = 1'b0;
            cur_in  = pos_a_ff + POS_W'(1);
            end_in  = pos_a_ff + POS_W'(1);
         end
      end else if (cmd.load_hop) begin
         if (desc_ff && !flip_ff) begin
            cur_in = cur_ff - POS_W'(1);
         end else begin
            cur_in  = cur_ff + POS_W'(1);
            desc_in = 1'b0;
            flip_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      end_ff  <= end_in;
      desc_ff <= desc_in;
      flip_ff <= flip_in;
   end

   assign node_addr = desc_in ? (cur_in - POS_W'(1)) : cur_in;

   always_ff @(posedge clock) begin
      if (cmd.write_mem) begin
         o2n_mem[pos_ff[POS_W-1:0]]  <= node_ff[POS_W-1:0];
         n2o_mem[node_ff[POS_W-1:0]] <= pos_ff[POS_W-1:0];
         len_mem[pos_ff[POS_W-1:0]]  <= edge_wide[LEN_BITS-1:0];
      end
      pos_a_ff       <= n2o_mem[node_ff[POS_W-1:0]];
      pos_b_ff       <= n2o_mem[tgt_ff[POS_W-1:0]];
      hop_node_rd_ff <= o2n_mem[node_addr];
      hop_len_rd_ff  <= len_mem[cur_in];
   end

   assign len_wide  = {{LEN_W{1'b0}}, hop_len_rd_ff};
   assign node_wide = {{NODE_W{1'b0}}, hop_node_rd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_single || cmd.load_hop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_single) begin
         hop_node_ff <= '0;
         hop_len_ff  <= '0;
         empty_ff    <= !cmd.single_err;
         err_ff      <= cmd.single_err;
         last_ff     <= 1'b1;
      end else if (cmd.load_hop) begin
         hop_node_ff <= node_wide[NODE_W-1:0];
         hop_len_ff  <= len_wide[LEN_W-1:0];
         empty_ff    <= 1'b0;
         err_ff      <= 1'b0;
         last_ff     <= status.hop_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hop_node    = hop_node_ff;
   assign rsp_hop_len     = hop_len_ff;
   assign rsp_path_empty  = empty_ff;
   assign rsp_range_error = err_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/chain_graph_path_engine.sv @@
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  func, position, node_id, edge_len, target_node
// rsp       out        rsp_valid/rsp_stall  hop_node, hop_len, path_empty, range_error, last
// csr       in         csr_wr_en            node_count
//
// One request is worked on at a time; a load writes the stores in the check state, then the next request is taken.
// A path or neighbour query is captured, checked and located; it then gives one hop
// result per cycle while the output register is free, and holds the request side until
// its last hop. Hops come from the position store through a registered read port.
// Reset is synchronous and clears the controller, the output valid and node_count.
// A stalled result holds the output register and the hop walk waits on it.
`default_nettype none

module chain_graph_path_engine #(
   parameter int MAX_NODES = cgpe_pkg::MAX_NODES_DEF,
   parameter int LEN_BITS  = cgpe_pkg::LEN_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire [cgpe_pkg::FUNC_W-1:0]   req_func,
   input  wire [cgpe_pkg::NODE_W-1:0]   req_position,
   input  wire [cgpe_pkg::NODE_W-1:0]   req_node_id,
   input  wire [cgpe_pkg::LEN_W-1:0]    req_edge_len,
   input  wire [cgpe_pkg::NODE_W-1:0]   req_target_node,
   input  wire                          csr_wr_en,
   input  wire [cgpe_pkg::CNT_W-1:0]    csr_wr_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [cgpe_pkg::NODE_W-1:0]  rsp_hop_node,
   output logic [cgpe_pkg::LEN_W-1:0]   rsp_hop_len,
   output logic                         rsp_path_empty,
   output logic                         rsp_range_error,
   output logic                         rsp_last
);
   import cgpe_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   cgpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cgpe_datapath #(
      .MAX_NODES (MAX_NODES),
      .LEN_BITS  (LEN_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_node_id     (req_node_id),
      .req_edge_len    (req_edge_len),
      .req_target_node (req_target_node),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hop_node    (rsp_hop_node),
      .rsp_hop_len     (rsp_hop_len),
      .rsp_path_empty  (rsp_path_empty),
      .rsp_range_error (rsp_range_error),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
